// ===== hw/rtl/cmvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_pkg
// Shared codes, widths and types of the complex matrix-vector multiplier.
// ----------------------------------------------------------------------------
package cmvm_pkg;

  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 5;
  localparam int CFG_W      = 6;
  localparam int CFG_ADDR_W = 2;

  localparam logic [MODE_W-1:0] MODE_MATRIX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VECTOR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_IN_USE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_LENGTH = 2'd1;

  localparam logic [CFG_W-1:0] CFG_RESET_DIM = 6'd1;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/cmvm_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_store
// Matrix and vector memories: one write and one registered read per cycle each.
// ----------------------------------------------------------------------------
module cmvm_store #(
  parameter int MAX_DIM    = 32,
  parameter int PART_WIDTH = 16,
  parameter int IDX_W      = 5,
  parameter int ADDR_W     = 10
) (
  input  logic                    clk,
  input  logic                    mat_we,
  input  logic [ADDR_W-1:0]       mat_waddr,
  input  logic [2*PART_WIDTH-1:0] mat_wdata,
  input  logic [ADDR_W-1:0]       mat_raddr,
  output logic [2*PART_WIDTH-1:0] mat_q,
  input  logic                    vec_we,
  input  logic [IDX_W-1:0]        vec_waddr,
  input  logic [2*PART_WIDTH-1:0] vec_wdata,
  input  logic [IDX_W-1:0]        vec_raddr,
  output logic [2*PART_WIDTH-1:0] vec_q
);

  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;

  logic [2*PART_WIDTH-1:0] mat_mem [MAT_DEPTH];
  logic [2*PART_WIDTH-1:0] vec_mem [MAX_DIM];

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_q <= vec_mem[vec_raddr];
  end

endmodule

// ===== hw/rtl/cmvm_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmvm_mac
// Complex multiply-accumulate lane: product, term and accumulator stages,
// with round-to-nearest and saturation of the finished row sum.
// ----------------------------------------------------------------------------
module cmvm_mac
  import cmvm_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int PART_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mac_ctrl_t                    ctrl,
  input  logic [2*PART_WIDTH-1:0]      mat_q,
  input  logic [2*PART_WIDTH-1:0]      vec_q,
  output logic                         busy,
  output logic signed [PART_WIDTH-1:0] res_re,
  output logic signed [PART_WIDTH-1:0] res_im
);

  localparam int PROD_W  = 2 * PART_WIDTH;
  localparam int TERM_W  = PROD_W + 1;
  localparam int EXACT_W = PROD_W + $clog2(MAX_DIM) + 2;
  localparam int ACC_W   = (EXACT_W > 64) ? 64 : EXACT_W;
  localparam int FRAC    = PART_WIDTH - 2;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((64'sd1 <<< (PART_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (FRAC - 1));

  logic                         v1, v2, v3;
  logic signed [PART_WIDTH-1:0] mr, mi, vr, vi;
  logic signed [PROD_W-1:0]     prr, pii, pri, pir;
  logic signed [TERM_W-1:0]     t_re, t_im;
  logic signed [ACC_W-1:0]      acc_re, acc_im;

  function automatic logic signed [PART_WIDTH-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sh;
    sum = a + HALF;
    sh  = sum >>> FRAC;
    if (sh > SAT_HI) begin
      round_sat = PART_WIDTH'(SAT_HI);
    end else if (sh < SAT_LO) begin
      round_sat = PART_WIDTH'(SAT_LO);
    end else begin
      round_sat = PART_WIDTH'(sh);
    end
  endfunction

  assign mr = signed'(mat_q[PROD_W-1:PART_WIDTH]);
  assign mi = signed'(mat_q[PART_WIDTH-1:0]);
  assign vr = signed'(vec_q[PROD_W-1:PART_WIDTH]);
  assign vi = signed'(vec_q[PART_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prr <= vr * mr;
      pii <= vi * mi;
      pri <= vr * mi;
      pir <= vi * mr;
    end
    if (v2) begin
      t_re <= TERM_W'(prr) - TERM_W'(pii);
      t_im <= TERM_W'(pri) + TERM_W'(pir);
    end
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v3) begin
      acc_re <= acc_re + ACC_W'(t_re);
      acc_im <= acc_im + ACC_W'(t_im);
    end
  end

  assign busy   = ctrl.issue | v1 | v2 | v3;
  assign res_re = round_sat(acc_re);
  assign res_im = round_sat(acc_im);

  a_clear_when_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |-> !(v1 || v2 || v3))
    else $error("accumulator cleared with terms in flight");

  a_term_follows_issue: assert property (@(posedge clk) disable iff (rst)
    ctrl.issue |=> ##2 v3)
    else $error("issued read did not reach the accumulator stage");

  a_no_clear_during_issue: assert property (@(posedge clk) disable iff (rst)
    ctrl.issue |-> !ctrl.clear)
    else $error("clear and issue in the same cycle");

endmodule

// ===== hw/rtl/complex_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matrix_vector_multiply
// Loads a complex Q2.14 matrix and vector into memories and streams out the
// product vector, one saturated complex element per matrix row.
// ----------------------------------------------------------------------------
// A matrix or vector write beat is taken one per cycle while no compute run is
// in progress; a compute beat holds the input until the output register has
// taken its size error beat or its last row result. One multiply-accumulate
// lane reads one matrix entry per cycle from the matrix memory port, then
// waits for the read, product and term stages to drain before the
// row result is rounded into the output register. An output stall holds it in emit.
// Both memories power up undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module complex_matrix_vector_multiply
  import cmvm_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int PART_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [CFG_ADDR_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [MODE_W-1:0]            mode,
  input  logic [INDEX_W-1:0]           row_index,
  input  logic [INDEX_W-1:0]           col_index,
  input  logic signed [PART_WIDTH-1:0] value_re,
  input  logic signed [PART_WIDTH-1:0] value_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PART_WIDTH-1:0] result_re,
  output logic signed [PART_WIDTH-1:0] result_im,
  output logic [INDEX_W-1:0]           result_index,
  output logic                         last,
  output logic                         size_error
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                      state, state_next;
  logic [CFG_W-1:0]            rows_in_use, vector_length;
  logic [IDX_W-1:0]            row, col, last_row, last_col;
  logic [ADDR_W-1:0]           row_base;
  logic                        err;
  logic                        in_take, out_free, bad_size;
  logic                        mat_we, vec_we;
  logic [ADDR_W-1:0]           mat_waddr, mat_raddr;
  logic [2*PART_WIDTH-1:0]     wdata, mat_q, vec_q;
  mac_ctrl_t                   mac_ctrl;
  logic                        mac_busy;
  logic signed [PART_WIDTH-1:0] res_re, res_im;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_row = IDX_W'(rows_in_use - CFG_W'(1));
  assign last_col = IDX_W'(vector_length - CFG_W'(1));
  assign bad_size = (rows_in_use != vector_length) || (rows_in_use == '0) ||
                    (32'(rows_in_use) > MAX_DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= CFG_RESET_DIM;
      vector_length <= CFG_RESET_DIM;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE:   rows_in_use   <= cfg_data;
        REG_VECTOR_LENGTH: vector_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wdata     = {value_re, value_im};
  assign mat_we    = in_take && (mode == MODE_MATRIX) &&
                     (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign vec_we    = in_take && (mode == MODE_VECTOR) && (32'(col_index) < MAX_DIM);
  assign mat_waddr = ADDR_W'(row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index);
  assign mat_raddr = row_base + ADDR_W'(col);

  cmvm_store #(
    .MAX_DIM    (MAX_DIM),
    .PART_WIDTH (PART_WIDTH),
    .IDX_W      (IDX_W),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk       (clk),
    .mat_we    (mat_we),
    .mat_waddr (mat_waddr),
    .mat_wdata (wdata),
    .mat_raddr (mat_raddr),
    .mat_q     (mat_q),
    .vec_we    (vec_we),
    .vec_waddr (IDX_W'(col_index)),
    .vec_wdata (wdata),
    .vec_raddr (col),
    .vec_q     (vec_q)
  );

  cmvm_mac #(
    .MAX_DIM    (MAX_DIM),
    .PART_WIDTH (PART_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .mat_q  (mat_q),
    .vec_q  (vec_q),
    .busy   (mac_busy),
    .res_re (res_re),
    .res_im (res_im)
  );

  always_comb begin
    state_next     = state;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.issue = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_take && (mode == MODE_COMPUTE)) begin
          if (bad_size) begin
            state_next = S_EMIT;
          end else begin
            mac_ctrl.clear = 1'b1;
            state_next     = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        mac_ctrl.issue = 1'b1;
        if (col == last_col) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (err || (row == last_row)) begin
            state_next = S_IDLE;
          end else begin
            mac_ctrl.clear = 1'b1;
            state_next     = S_ISSUE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err   <= 1'b0;
      row   <= '0;
      col   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          row      <= '0;
          col      <= '0;
          row_base <= '0;
          err      <= in_take && (mode == MODE_COMPUTE) && bad_size;
        end
        S_ISSUE: begin
          col <= (col == last_col) ? '0 : col + IDX_W'(1);
        end
        S_EMIT: begin
          if (out_free) begin
            err      <= 1'b0;
            row      <= row + IDX_W'(1);
            row_base <= row_base + ADDR_W'(MAX_DIM);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      if (err) begin
        result_re    <= '0;
        result_im    <= '0;
        result_index <= '0;
        last         <= 1'b1;
        size_error   <= 1'b1;
      end else begin
        result_re    <= res_re;
        result_im    <= res_im;
        result_index <= INDEX_W'(row);
        last         <= (row == last_row);
        size_error   <= 1'b0;
      end
    end
  end

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && size_error) |-> last)
    else $error("error beat not flagged last");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !err) |-> !mac_busy)
    else $error("row result taken while the lane is busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("output beat loaded outside of emit");

  a_no_write_during_compute: assert property (@(posedge clk) disable iff (rst)
    mac_ctrl.issue |-> !(mat_we || vec_we))
    else $error("memory write during a compute run");

endmodule

// ===== verif/complex_mv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_mv_checker
// Watches the configuration, load/compute and result channels of the complex
// matrix-vector multiplier. Keeps its own copy of the matrix, the vector and
// both dimension registers, predicts the product vector of each compute beat
// and compares every result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module complex_mv_checker
  import cmvm_pkg::*;
#(
  parameter int MAX_DIM    = 32,
  parameter int PART_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [CFG_ADDR_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [MODE_W-1:0]            mode,
  input  logic [INDEX_W-1:0]           row_index,
  input  logic [INDEX_W-1:0]           col_index,
  input  logic signed [PART_WIDTH-1:0] value_re,
  input  logic signed [PART_WIDTH-1:0] value_im,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [PART_WIDTH-1:0] result_re,
  input  logic signed [PART_WIDTH-1:0] result_im,
  input  logic [INDEX_W-1:0]           result_index,
  input  logic                         last,
  input  logic                         size_error,
  output int                           fail_count,
  output int                           pending,
  output int                           result_count
);

  typedef struct packed {
    logic signed [PART_WIDTH-1:0] re;
    logic signed [PART_WIDTH-1:0] im;
    logic [INDEX_W-1:0]           index;
    logic                         last;
    logic                         size_error;
  } product_t;

  logic signed [PART_WIDTH-1:0] mat_re [MAX_DIM*MAX_DIM];
  logic signed [PART_WIDTH-1:0] mat_im [MAX_DIM*MAX_DIM];
  logic signed [PART_WIDTH-1:0] vec_re [MAX_DIM];
  logic signed [PART_WIDTH-1:0] vec_im [MAX_DIM];
  logic [CFG_W-1:0]             rows_cfg;
  logic [CFG_W-1:0]             length_cfg;
  product_t                     expected_products [$];
  bit                           compute_predicted;

  function automatic logic signed [PART_WIDTH-1:0] round_saturate(longint acc);
    longint hi;
    longint lo;
    longint v;
    hi = (longint'(1) <<< (PART_WIDTH - 1)) - 1;
    lo = -hi - 1;
    v  = (acc + (longint'(1) <<< (PART_WIDTH - 3))) >>> (PART_WIDTH - 2);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[PART_WIDTH-1:0];
  endfunction

  task automatic predict_product_vector();
    product_t p;
    longint   acc_re;
    longint   acc_im;
    longint   mr;
    longint   mi;
    longint   vr;
    longint   vi;
    int       k;
    if (rows_cfg != length_cfg || rows_cfg == 0 || rows_cfg > MAX_DIM) begin
      p            = '0;
      p.last       = 1'b1;
      p.size_error = 1'b1;
      expected_products = {expected_products, p};
    end else begin
      for (int r = 0; r < rows_cfg; r++) begin
        acc_re = 0;
        acc_im = 0;
        for (int c = 0; c < length_cfg; c++) begin
          k      = r * MAX_DIM + c;
          mr     = mat_re[k];
          mi     = mat_im[k];
          vr     = vec_re[c];
          vi     = vec_im[c];
          acc_re = acc_re + vr * mr - vi * mi;
          acc_im = acc_im + vr * mi + vi * mr;
        end
        p.re         = round_saturate(acc_re);
        p.im         = round_saturate(acc_im);
        p.index      = INDEX_W'(r);
        p.last       = (r + 1 == rows_cfg);
        p.size_error = 1'b0;
        expected_products = {expected_products, p};
      end
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    product_t oldest;
    if (rst) begin
      rows_cfg          = CFG_RESET_DIM;
      length_cfg        = CFG_RESET_DIM;
      compute_predicted = 1'b0;
      expected_products.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_ROWS_IN_USE:   rows_cfg = cfg_data;
          REG_VECTOR_LENGTH: length_cfg = cfg_data;
          default: ;
        endcase
      end
      // predict on first sight: results may leave while the compute beat is held
      if (in_valid && mode == MODE_COMPUTE && !compute_predicted) begin
        predict_product_vector();
        compute_predicted = 1'b1;
      end
      if (in_valid && !in_stall) begin
        case (mode)
          MODE_MATRIX: begin
            if (row_index < MAX_DIM && col_index < MAX_DIM) begin
              mat_re[row_index * MAX_DIM + col_index] = value_re;
              mat_im[row_index * MAX_DIM + col_index] = value_im;
            end
          end
          MODE_VECTOR: begin
            if (col_index < MAX_DIM) begin
              vec_re[col_index] = value_re;
              vec_im[col_index] = value_im;
            end
          end
          default: ;
        endcase
        compute_predicted = 1'b0;
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_products.size() == 0) begin
          $error("result beat for row %0d with no product pending", result_index);
          fail_count++;
        end else begin
          oldest = expected_products.pop_front();
          check_field("result_re", $signed(oldest.re), $signed(result_re));
          check_field("result_im", $signed(oldest.im), $signed(result_im));
          check_field("result_index", oldest.index, result_index);
          check_field("last", oldest.last, last);
          check_field("size_error", oldest.size_error, size_error);
        end
      end
    end
    pending = expected_products.size();
  end

endmodule

// ===== verif/tb_complex_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_matrix_vector_multiply
// Drives matrix loads, vector loads and compute beats into the complex
// matrix-vector multiplier under random input gaps and output stalls, steps
// through square, mismatched, zero and oversized dimensions, and gives the
// verdict from the failure and pending counts of the checker beside the block.
// ----------------------------------------------------------------------------
module tb_complex_matrix_vector_multiply;
  import cmvm_pkg::*;

  localparam int MAX_DIM      = 32;
  localparam int PART_WIDTH   = 16;
  localparam int CLK_PERIOD   = 4;
  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_ITEMS   = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HALF_STEP    = 1 << (PART_WIDTH - 3);
  localparam int FINAL_DIM    = 6;

  localparam logic [MODE_W-1:0]     MODE_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [CFG_W-1:0]      CFG_ALL_ONES = '1;

  localparam logic signed [PART_WIDTH-1:0] PART_MIN = {1'b1, {(PART_WIDTH - 1){1'b0}}};
  localparam logic signed [PART_WIDTH-1:0] PART_MAX = {1'b0, {(PART_WIDTH - 1){1'b1}}};

  logic                         clk;
  logic                         rst;
  logic                         cfg_wen;
  logic [CFG_ADDR_W-1:0]        cfg_index;
  logic [CFG_W-1:0]             cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [MODE_W-1:0]            mode;
  logic [INDEX_W-1:0]           row_index;
  logic [INDEX_W-1:0]           col_index;
  logic signed [PART_WIDTH-1:0] value_re;
  logic signed [PART_WIDTH-1:0] value_im;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [PART_WIDTH-1:0] result_re;
  logic signed [PART_WIDTH-1:0] result_im;
  logic [INDEX_W-1:0]           result_index;
  logic                         last;
  logic                         size_error;
  int                           fail_count;
  int                           pending;
  int                           result_count;

  bit               m_written [MAX_DIM][MAX_DIM];
  bit               v_written [MAX_DIM];
  logic [CFG_W-1:0] rows_now;
  logic [CFG_W-1:0] length_now;
  bit               calm;
  int               items_sent;
  int               computes_sent;
  int               dim_settings;
  int               cycle_count;

  complex_matrix_vector_multiply #(
    .MAX_DIM    (MAX_DIM),
    .PART_WIDTH (PART_WIDTH)
  ) dut (.*);

  complex_mv_checker #(
    .MAX_DIM    (MAX_DIM),
    .PART_WIDTH (PART_WIDTH)
  ) checker_i (.*);

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timed out after %0d cycles with %0d products pending", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 10))
        @(negedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [PART_WIDTH-1:0] pick_part();
    case ($urandom_range(0, 7))
      0:       return PART_MIN;
      1:       return PART_MAX;
      2:       return '0;
      default: return PART_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(int n);
    if (n >= 1 && n <= MAX_DIM && $urandom_range(0, 3) != 0) begin
      return INDEX_W'($urandom_range(0, n - 1));
    end
    return INDEX_W'($urandom_range(0, MAX_DIM - 1));
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] m,
                           input logic [INDEX_W-1:0] r,
                           input logic [INDEX_W-1:0] c,
                           input logic signed [PART_WIDTH-1:0] re,
                           input logic signed [PART_WIDTH-1:0] im);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    row_index <= r;
    col_index <= c;
    value_re  <= re;
    value_im  <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (m)
      MODE_MATRIX:  m_written[r][c] = 1'b1;
      MODE_VECTOR:  v_written[c] = 1'b1;
      MODE_COMPUTE: computes_sent++;
      default: ;
    endcase
    if (m != MODE_UNUSED) items_sent++;
  endtask

  // drop valid, wait out every pending product, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] length);
    settle();
    set_reg(REG_ROWS_IN_USE, rows);
    set_reg(REG_VECTOR_LENGTH, length);
    rows_now   = rows;
    length_now = length;
    dim_settings++;
  endtask

  // load any entry the product would read that was never written, then compute
  task automatic compute_product();
    if (rows_now == length_now && rows_now >= 1 && rows_now <= MAX_DIM) begin
      for (int r = 0; r < rows_now; r++) begin
        for (int c = 0; c < length_now; c++) begin
          if (!m_written[r][c]) begin
            send_item(MODE_MATRIX, INDEX_W'(r), INDEX_W'(c), pick_part(), pick_part());
          end
        end
      end
      for (int c = 0; c < length_now; c++) begin
        if (!v_written[c]) begin
          send_item(MODE_VECTOR, INDEX_W'($urandom), INDEX_W'(c), pick_part(), pick_part());
        end
      end
    end
    send_item(MODE_COMPUTE, INDEX_W'($urandom), INDEX_W'($urandom),
              PART_WIDTH'($urandom), PART_WIDTH'($urandom));
  endtask

  initial begin
    int dim;
    int directed_items;
    rst        = 1'b1;
    cfg_wen    = 1'b0;
    cfg_index  = REG_ROWS_IN_USE;
    cfg_data   = CFG_RESET_DIM;
    in_valid   = 1'b0;
    mode       = MODE_MATRIX;
    row_index  = '0;
    col_index  = '0;
    value_re   = '0;
    value_im   = '0;
    calm       = 1'b0;
    rows_now   = CFG_RESET_DIM;
    length_now = CFG_RESET_DIM;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // full-scale entries: cancelling real part, saturating imaginary part
    send_item(MODE_MATRIX, '0, '0, PART_MIN, PART_MIN);
    send_item(MODE_VECTOR, '0, '0, PART_MIN, PART_MIN);
    compute_product();
    send_item(MODE_VECTOR, '0, '0, PART_MAX, PART_MAX);
    compute_product();
    send_item(MODE_UNUSED, '1, '1, PART_MAX, PART_MIN);
    // half-LSB ties: positive rounds up, negative rounds to zero
    send_item(MODE_MATRIX, '0, '0, PART_WIDTH'(1), '0);
    send_item(MODE_VECTOR, '0, '0, PART_WIDTH'(HALF_STEP), '0);
    compute_product();
    send_item(MODE_MATRIX, '0, '0, PART_WIDTH'(-1), '0);
    compute_product();
    set_dims(CFG_W'(2), CFG_W'(3));
    compute_product();
    set_dims('0, '0);
    compute_product();
    set_dims(CFG_W'(MAX_DIM + 1), CFG_W'(MAX_DIM + 1));
    compute_product();
    set_dims(CFG_ALL_ONES, CFG_ALL_ONES);
    compute_product();
    settle();
    set_reg(REG_SPARE_A, CFG_W'(1));
    set_reg(REG_SPARE_B, '0);
    compute_product();
    set_dims(CFG_W'(2), CFG_W'(2));
    send_item(MODE_MATRIX, INDEX_W'(1), '0, PART_MAX, PART_MAX);
    send_item(MODE_MATRIX, INDEX_W'(1), INDEX_W'(1), PART_MAX, PART_MAX);
    send_item(MODE_VECTOR, '1, '0, PART_MAX, PART_MIN);
    send_item(MODE_VECTOR, '0, INDEX_W'(1), PART_MIN, PART_MAX);
    compute_product();

    directed_items = items_sent;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: set_dims(CFG_W'($urandom), CFG_W'($urandom));
        1: begin
          dim = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1);
          set_dims(CFG_W'(dim), CFG_W'(dim));
        end
        2: begin
          dim = $urandom_range(7, 8);
          set_dims(CFG_W'(dim), CFG_W'(dim));
        end
        default: begin
          dim = $urandom_range(1, 6);
          set_dims(CFG_W'(dim), CFG_W'(dim));
        end
      endcase
      repeat ($urandom_range(4, 20)) begin
        case ($urandom_range(0, 15))
          0: send_item(MODE_UNUSED, INDEX_W'($urandom), INDEX_W'($urandom),
                       pick_part(), pick_part());
          1, 2: compute_product();
          3, 4, 5: send_item(MODE_VECTOR, INDEX_W'($urandom), pick_index(length_now),
                             pick_part(), pick_part());
          default: send_item(MODE_MATRIX, pick_index(rows_now), pick_index(length_now),
                             pick_part(), pick_part());
        endcase
      end
      compute_product();
      if (items_sent - directed_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
    end

    set_dims(CFG_W'(FINAL_DIM), CFG_W'(FINAL_DIM));
    compute_product();
    compute_product();
    settle();

    $display("Sent %0d load and compute beats: %0d compute runs over %0d dimension settings.",
             items_sent, computes_sent, dim_settings);
    $display("Checked %0d result beats against predicted product vectors.", result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
